// File: design/lpd_pkg.sv
`default_nettype none

package lpd_pkg;

    // Field widths fixed by the stream format
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned TOTAL_W = 32;

    // One decoded transaction passed from the parser to the output side
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [WORD_W-1:0] length;
        logic [WORD_W-1:0] flags;
        logic              err;
    } t_cmd;

endpackage

`default_nettype wire

// File: design/lpd_front.sv
`default_nettype none

// Header parser: tracks the frame phase and turns payload bytes and
// header faults into queued transactions.
module lpd_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [lpd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic [lpd_pkg::WORD_W-1:0]  i_max_len,
    input  wire logic                        i_q_full,
    output logic                             o_push,
    output lpd_pkg::t_cmd                    o_cmd
);
    import lpd_pkg::*;

    localparam logic [2:0] PH_LEN_HI  = 3'd0;
    localparam logic [2:0] PH_LEN_LO  = 3'd1;
    localparam logic [2:0] PH_FLG_HI  = 3'd2;
    localparam logic [2:0] PH_FLG_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    logic [2:0]        r_phase, n_phase;
    logic [WORD_W-1:0] r_len,   n_len;
    logic [WORD_W-1:0] r_flags, n_flags;
    logic [WORD_W-1:0] r_left,  n_left;
    logic              w_acc;
    logic              w_bad;

    assign o_stall = i_q_full;
    assign w_acc   = i_valid && !i_q_full;
    // length is complete once the second header byte arrives; it is checked on the fourth
    assign w_bad   = (r_len == '0) || (r_len > i_max_len);

    // Phase sequencing and transaction build
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_flags = r_flags;
        n_left  = r_left;
        o_push  = 1'b0;
        o_cmd.data   = i_rx_byte;
        o_cmd.last   = (r_left == WORD_W'(1));
        o_cmd.length = r_len;
        o_cmd.flags  = r_flags;
        o_cmd.err    = 1'b0;
        if (w_acc) begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    n_len   = {i_rx_byte, r_len[BYTE_W-1:0]};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {r_len[WORD_W-1:BYTE_W], i_rx_byte};
                    n_phase = PH_FLG_HI;
                end
                PH_FLG_HI: begin
                    n_flags = {i_rx_byte, r_flags[BYTE_W-1:0]};
                    n_phase = PH_FLG_LO;
                end
                PH_FLG_LO: begin
                    n_flags = {r_flags[WORD_W-1:BYTE_W], i_rx_byte};
                    if (w_bad) begin
                        n_phase     = PH_ERROR;
                        o_push      = 1'b1;
                        o_cmd.data  = '0;
                        o_cmd.last  = 1'b0;
                        o_cmd.flags = n_flags;
                        o_cmd.err   = 1'b1;
                    end else begin
                        n_left  = r_len;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_push = 1'b1;
                    n_left = r_left - 1'b1;
                    if (r_left == WORD_W'(1)) begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_ERROR: begin
                    // sticky: bytes are swallowed until reset
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_HI;
            r_len   <= '0;
            r_flags <= '0;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_flags <= n_flags;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

// File: design/lpd_fifo.sv
`default_nettype none

// Short queue between parser and output side
module lpd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lpd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output lpd_pkg::t_cmd      o_head
);
    import lpd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Pointer wrap for any depth
    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/lpd_back.sv
`default_nettype none

// Output side: keeps running totals and holds the result register
module lpd_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_empty,
    input  wire lpd_pkg::t_cmd                i_head,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [lpd_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic                              o_last_byte,
    output logic [lpd_pkg::WORD_W-1:0]        o_frame_length,
    output logic [lpd_pkg::WORD_W-1:0]        o_frame_flags,
    output logic                              o_protocol_error,
    output logic [lpd_pkg::TOTAL_W-1:0]       o_frames_done,
    output logic [lpd_pkg::TOTAL_W-1:0]       o_bytes_done
);
    import lpd_pkg::*;

    logic                r_valid;
    t_cmd                r_res;
    logic [TOTAL_W-1:0]  r_frames, n_frames;
    logic [TOTAL_W-1:0]  r_bytes,  n_bytes;

    // Load when the result register is free or being drained
    assign o_pop = !i_q_empty && (!r_valid || !i_stall);

    // Last byte already counts its own frame
    always_comb begin
        n_frames = r_frames;
        n_bytes  = r_bytes;
        if (i_head.last) begin
            n_frames = r_frames + 1'b1;
            n_bytes  = r_bytes + TOTAL_W'(i_head.length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_frames <= '0;
            r_bytes  <= '0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_frames <= n_frames;
            r_bytes  <= n_bytes;
        end else if (!i_stall) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    assign o_valid          = r_valid;
    assign o_payload_byte   = r_res.data;
    assign o_last_byte      = r_res.last;
    assign o_frame_length   = r_res.length;
    assign o_frame_flags    = r_res.flags;
    assign o_protocol_error = r_res.err;
    assign o_frames_done    = r_frames;
    assign o_bytes_done     = r_bytes;

endmodule

`default_nettype wire

// File: design/length_prefixed_deframer.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_rx_byte
// output    out        o_valid / i_stall   o_payload_byte .. o_bytes_done
// config    in         i_cfg_we            i_cfg_wdata (frame length limit)
//
// One byte is taken per cycle while the queue is not full; a result goes from
// the parser into the queue, then from the queue into the result register.
// Throughput is set by the queue: input stalls only while it is full.
// Reset is synchronous, active low; the limit returns to 1518.
// After a header fault the parser swallows all bytes until reset.
module length_prefixed_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [lpd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic                        i_cfg_we,
    input  wire logic [lpd_pkg::WORD_W-1:0]  i_cfg_wdata,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [lpd_pkg::BYTE_W-1:0]       o_payload_byte,
    output logic                             o_last_byte,
    output logic [lpd_pkg::WORD_W-1:0]       o_frame_length,
    output logic [lpd_pkg::WORD_W-1:0]       o_frame_flags,
    output logic                             o_protocol_error,
    output logic [lpd_pkg::TOTAL_W-1:0]      o_frames_done,
    output logic [lpd_pkg::TOTAL_W-1:0]      o_bytes_done
);
    import lpd_pkg::*;

    localparam logic [WORD_W-1:0] MAX_LEN_RST = WORD_W'(1518);

    logic [WORD_W-1:0] r_max_len;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    t_cmd              w_cmd;
    t_cmd              w_head;

    // Frame length limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    lpd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_max_len (r_max_len),
        .i_q_full  (w_full),
        .o_push    (w_push),
        .o_cmd     (w_cmd)
    );

    lpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    lpd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_empty),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_payload_byte   (o_payload_byte),
        .o_last_byte      (o_last_byte),
        .o_frame_length   (o_frame_length),
        .o_frame_flags    (o_frame_flags),
        .o_protocol_error (o_protocol_error),
        .o_frames_done    (o_frames_done),
        .o_bytes_done     (o_bytes_done)
    );

    // The parser never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    // A fault transaction carries no byte and no end mark
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_protocol_error) |-> (!o_last_byte && o_payload_byte == '0))
        else $error("malformed fault transaction");

    // Nothing is queued right after a fault
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_cmd.err) |=> !w_push)
        else $error("transaction queued after fault");

    // Totals advance only when a frame completes
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_head.last) |=> $stable(o_frames_done))
        else $error("frame total moved mid-frame");

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;

    import lpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned PRINT_CAP    = 40;
    localparam logic [15:0] RESET_LIMIT  = 16'd1518;

    // Parser position within a frame
    typedef enum logic [2:0] {
        AWAIT_LEN_HI,
        AWAIT_LEN_LO,
        AWAIT_FLG_HI,
        AWAIT_FLG_LO,
        IN_PAYLOAD,
        HALTED
    } t_deframe_phase;

    // Ways of provoking the header fault
    typedef enum int {
        FAULT_ZERO_LEN,
        FAULT_OVER_LIMIT,
        FAULT_ZERO_LIMIT
    } t_fault_kind;

    // One result transaction as seen on the output side
    typedef struct packed {
        t_cmd                cmd;
        logic [TOTAL_W-1:0] frames;
        logic [TOTAL_W-1:0] bytes;
    } t_deframe_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [BYTE_W-1:0]   i_rx_byte   = '0;
    logic                i_cfg_we    = 1'b0;
    logic [WORD_W-1:0]   i_cfg_wdata = '0;
    logic                i_stall     = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [BYTE_W-1:0]   o_payload_byte;
    logic                o_last_byte;
    logic [WORD_W-1:0]   o_frame_length;
    logic [WORD_W-1:0]   o_frame_flags;
    logic                o_protocol_error;
    logic [TOTAL_W-1:0]  o_frames_done;
    logic [TOTAL_W-1:0]  o_bytes_done;

    length_prefixed_deframer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_payload_byte   (o_payload_byte),
        .o_last_byte      (o_last_byte),
        .o_frame_length   (o_frame_length),
        .o_frame_flags    (o_frame_flags),
        .o_protocol_error (o_protocol_error),
        .o_frames_done    (o_frames_done),
        .o_bytes_done     (o_bytes_done)
    );

    always #5 i_clk = ~i_clk;

    // Deframer model state
    t_deframe_phase      ph_q      = AWAIT_LEN_HI;
    logic [WORD_W-1:0]   limit_q   = RESET_LIMIT;
    logic [WORD_W-1:0]   len_q     = '0;
    logic [WORD_W-1:0]   flags_q   = '0;
    logic [WORD_W-1:0]   left_q    = '0;
    logic [TOTAL_W-1:0]  frames_q  = '0;
    logic [TOTAL_W-1:0]  bytes_q   = '0;

    t_deframe_result     pending_results[$];
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count    = 0;

    // Idling controls shared by the test tasks and the stall driver
    bit                  steady_send  = 1'b0;
    bit                  steady_recv  = 1'b0;
    int unsigned         hold_request = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what, got, exp);
    endtask

    function automatic void queue_result(input logic [7:0] data, input logic last,
                                         input logic err);
        t_deframe_result r;
        r.cmd.data   = data;
        r.cmd.last   = last;
        r.cmd.length = len_q;
        r.cmd.flags  = flags_q;
        r.cmd.err    = err;
        r.frames     = frames_q;
        r.bytes      = bytes_q;
        pending_results.push_back(r);
    endfunction

    // Advance the model by one accepted input byte
    function automatic void deframe_byte(input logic [7:0] b);
        case (ph_q)
            AWAIT_LEN_HI: begin
                len_q = {b, 8'h00};
                ph_q  = AWAIT_LEN_LO;
            end
            AWAIT_LEN_LO: begin
                len_q[7:0] = b;
                ph_q       = AWAIT_FLG_HI;
            end
            AWAIT_FLG_HI: begin
                flags_q = {b, 8'h00};
                ph_q    = AWAIT_FLG_LO;
            end
            AWAIT_FLG_LO: begin
                flags_q[7:0] = b;
                if (len_q == '0 || len_q > limit_q) begin
                    ph_q = HALTED;
                    queue_result(8'h00, 1'b0, 1'b1);
                end else begin
                    left_q = len_q;
                    ph_q   = IN_PAYLOAD;
                end
            end
            IN_PAYLOAD: begin
                left_q = left_q - 16'd1;
                if (left_q == '0) begin
                    frames_q = frames_q + 32'd1;
                    bytes_q  = bytes_q + 32'(len_q);
                    ph_q     = AWAIT_LEN_HI;
                    queue_result(b, 1'b1, 1'b0);
                end else begin
                    queue_result(b, 1'b0, 1'b0);
                end
            end
            default: ;
        endcase
    endfunction

    // Mostly short gaps, the odd long one
    function automatic int unsigned sender_gap();
        int unsigned r;
        if (steady_send)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte after a random gap; returns once it is taken
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_rx_byte = b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        deframe_byte(b);
    endtask

    task automatic send_header(input logic [15:0] len, input logic [15:0] flags);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(flags[15:8]);
        send_byte(flags[7:0]);
    endtask

    // fill < 0 gives random payload bytes
    task automatic send_frame(input int unsigned len, input logic [15:0] flags,
                              input int fill = -1);
        send_header(16'(len), flags);
        for (int unsigned i = 0; i < len; i++)
            send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame_limit(input logic [15:0] lim);
        wait_drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = lim;
        limit_q     = lim;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Field extremes at the reset limit
    task automatic test_directed_frames();
        send_frame(1, 16'hFFFF, 8'h00);
        send_frame(2, 16'h0000, 8'hFF);
        send_frame(3, 16'hA55A);
        wait_drain();
    endtask

    // Smallest and largest limits; frames right at the smallest one
    task automatic test_limit_extremes();
        set_frame_limit(16'd1);
        repeat (3) send_frame(1, 16'($urandom));
        set_frame_limit(16'hFFFF);
        send_frame(24, 16'($urandom));
        set_frame_limit(RESET_LIMIT);
        send_frame(24, 16'h5AA5);
        wait_drain();
    endtask

    // Well-formed frames of random size under several limits
    task automatic test_random_stream();
        int unsigned sent;
        int unsigned len;
        for (int seg = 0; seg < 4; seg++) begin
            set_frame_limit(seg == 0 ? 16'd2 : 16'($urandom_range(3, 64)));
            sent = 0;
            while (sent < 80) begin
                len = ($urandom_range(0, 3) == 0) ? limit_q : $urandom_range(1, limit_q);
                send_frame(len, 16'($urandom));
                sent += len + 4;
            end
        end
        set_frame_limit(RESET_LIMIT);
    endtask

    // Receiver holds off for a long stretch while the sender keeps going
    task automatic test_output_holdoff();
        hold_request = 150;
        steady_send  = 1'b1;
        send_frame(40, 16'($urandom));
        steady_send  = 1'b0;
        wait_drain();
    endtask

    // Sender pauses mid-frame until the output side has caught up
    task automatic test_sender_pause();
        send_header(16'd12, 16'($urandom));
        repeat (5) send_byte(8'($urandom));
        wait_drain();
        repeat (7) send_byte(8'($urandom));
        wait_drain();
    endtask

    // No idling on either side
    task automatic test_back_to_back();
        steady_send = 1'b1;
        steady_recv = 1'b1;
        repeat (6) send_frame($urandom_range(1, 10), 16'($urandom));
        steady_send = 1'b0;
        steady_recv = 1'b0;
        wait_drain();
    endtask

    // Bad header; the block then ignores everything, so this runs last
    task automatic test_header_fault();
        t_fault_kind kind;
        kind = t_fault_kind'($urandom_range(0, 2));
        case (kind)
            FAULT_ZERO_LEN: begin
                send_header(16'd0, 16'($urandom));
            end
            FAULT_OVER_LIMIT: begin
                set_frame_limit(16'($urandom_range(1, 65534)));
                send_header(16'($urandom_range(limit_q + 1, 65535)), 16'($urandom));
            end
            default: begin
                set_frame_limit(16'd0);
                send_header(16'($urandom), 16'($urandom));
            end
        endcase
        repeat (24) send_byte(8'($urandom));
        wait_drain();
    endtask

    // Output stall: random holds, or a long hold on request
    always @(negedge i_clk) begin
        int unsigned r;
        static int unsigned stall_left = 0;
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left != 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else if (steady_recv) begin
            i_stall = 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_stall = 1'b0;
            end else if (r < 97) begin
                i_stall    = 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_stall    = 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_deframe_result got;
        t_deframe_result exp;
        if (i_rst_n && o_valid && !i_stall) begin
            got.cmd.data   = o_payload_byte;
            got.cmd.last   = o_last_byte;
            got.cmd.length = o_frame_length;
            got.cmd.flags  = o_frame_flags;
            got.cmd.err    = o_protocol_error;
            got.frames     = o_frames_done;
            got.bytes      = o_bytes_done;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, payload_byte", 32'(o_payload_byte), 32'd0);
            end else begin
                exp = pending_results.pop_front();
                if (got.cmd.data !== exp.cmd.data)
                    report_mismatch("payload_byte", 32'(got.cmd.data), 32'(exp.cmd.data));
                if (got.cmd.last !== exp.cmd.last)
                    report_mismatch("last_byte", 32'(got.cmd.last), 32'(exp.cmd.last));
                if (got.cmd.length !== exp.cmd.length)
                    report_mismatch("frame_length", 32'(got.cmd.length), 32'(exp.cmd.length));
                if (got.cmd.flags !== exp.cmd.flags)
                    report_mismatch("frame_flags", 32'(got.cmd.flags), 32'(exp.cmd.flags));
                if (got.cmd.err !== exp.cmd.err)
                    report_mismatch("protocol_error", 32'(got.cmd.err), 32'(exp.cmd.err));
                if (got.frames !== exp.frames)
                    report_mismatch("frames_done", got.frames, exp.frames);
                if (got.bytes !== exp.bytes)
                    report_mismatch("bytes_done", got.bytes, exp.bytes);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_frames();
        test_limit_extremes();
        test_random_stream();
        test_output_holdoff();
        test_sender_pause();
        test_back_to_back();
        test_header_fault();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// File: length_prefixed_deframer.f
design/lpd_pkg.sv
design/lpd_front.sv
design/lpd_fifo.sv
design/lpd_back.sv
design/length_prefixed_deframer.sv
tb/tb.sv
